FILE: design/tomq_pkg.sv
// Shared types and codes for the timestamp ordered message queue.
`default_nettype none

package tomq_pkg;

   localparam int RSP_COUNT_WIDTH = 5;
   localparam int STATUS_WIDTH = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic ins;
      logic pop;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: design/tomq_cell.sv
// One sorted queue cell holding a single entry and shifting with its neighbors.
`default_nettype none

module tomq_cell #(
   parameter int TS_WIDTH = 32,
   parameter int HOST_WIDTH = 8,
   parameter int TAG_WIDTH = 16
) (
   input  wire                       clock,
   input  tomq_pkg::cell_cmd_type    cmd,
   input  wire                       occupied,
   input  wire  [TS_WIDTH-1:0]       new_ts,
   input  wire  [HOST_WIDTH-1:0]     new_host,
   input  wire  [TAG_WIDTH-1:0]      new_tag,
   input  wire                       left_takes,
   input  wire  [TS_WIDTH-1:0]       left_ts,
   input  wire  [HOST_WIDTH-1:0]     left_host,
   input  wire  [TAG_WIDTH-1:0]      left_tag,
   input  wire  [TS_WIDTH-1:0]       right_ts,
   input  wire  [HOST_WIDTH-1:0]     right_host,
   input  wire  [TAG_WIDTH-1:0]      right_tag,
   output logic                      takes_new,
   output logic [TS_WIDTH-1:0]       slot_ts_ff,
   output logic [HOST_WIDTH-1:0]     slot_host_ff,
   output logic [TAG_WIDTH-1:0]      slot_tag_ff,
   output logic [TS_WIDTH-1:0]       slot_ts_in,
   output logic [HOST_WIDTH-1:0]     slot_host_in,
   output logic [TAG_WIDTH-1:0]      slot_tag_in
);
   import tomq_pkg::*;

   logic key_not_above;

   always_comb begin
      key_not_above = (new_ts < slot_ts_ff) ||
                      ((new_ts == slot_ts_ff) && (new_host <= slot_host_ff));
      takes_new = !occupied || key_not_above;
      slot_ts_in = slot_ts_ff;
      slot_host_in = slot_host_ff;
      slot_tag_in = slot_tag_ff;
      if (cmd.ins) begin
         if (left_takes) begin
            slot_ts_in = left_ts;
            slot_host_in = left_host;
            slot_tag_in = left_tag;
         end else if (takes_new) begin
            slot_ts_in = new_ts;
            slot_host_in = new_host;
            slot_tag_in = new_tag;
         end
      end else if (cmd.pop) begin
         slot_ts_in = right_ts;
         slot_host_in = right_host;
         slot_tag_in = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      slot_ts_ff <= slot_ts_in;
      slot_host_ff <= slot_host_in;
      slot_tag_ff <= slot_tag_in;
   end

endmodule

`default_nettype wire

FILE: design/timestamp_ordered_message_queue.sv
// Top level of the timestamp ordered message queue built from a row of cells.
//
// A request transfer on the req_ channel carries an operation in req_tuser
// (0 inserts the message in req_tdata, 1 pops the head entry). Entries stay
// sorted by timestamp, then host id; an insert goes ahead of equal keys.
// Each request produces exactly one response transfer on the rsp_ channel
// with the new head entry, the entry count and a status (0 ok, 1 insert
// dropped because the queue is full, 2 pop on an empty queue).
// Every cell compares the new key with its own entry and shifts in the same
// cycle, so one request is taken per cycle while req_tready is high; its
// response is registered and visible in the cycle after the request transfer.
// The response register frees the request side: a new request is taken
// whenever the response register is empty or is being taken in the same
// cycle. While rsp_tready stays low the response holds and req_tready drops.
// Reset empties the queue and clears the response valid flag; entry data is
// not cleared, since only occupied cells are ever read.
`default_nettype none

module timestamp_ordered_message_queue #(
   parameter int DEPTH = 16,
   parameter int TS_WIDTH = 32,
   parameter int HOST_WIDTH = 8,
   parameter int TAG_WIDTH = 16,
   localparam int REQ_DATA_WIDTH = ((TS_WIDTH + HOST_WIDTH + TAG_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH =
      ((TS_WIDTH + HOST_WIDTH + TAG_WIDTH + tomq_pkg::RSP_COUNT_WIDTH + 7) / 8) * 8,
   localparam int RSP_USER_WIDTH = 1 + tomq_pkg::STATUS_WIDTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // msg_timestamp, msg_host, msg_tag
   input  wire  [REQ_DATA_WIDTH-1:0] req_tdata,
   // mode
   input  wire                       req_tuser,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // head_timestamp, head_host, head_tag, entry_count
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // head_valid, status
   output logic [RSP_USER_WIDTH-1:0] rsp_tuser
);
   import tomq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int ENTRY_WIDTH = TS_WIDTH + HOST_WIDTH + TAG_WIDTH;

   logic [TS_WIDTH-1:0]   new_ts;
   logic [HOST_WIDTH-1:0] new_host;
   logic [TAG_WIDTH-1:0]  new_tag;
   logic                  accept;
   logic                  full;
   logic                  empty;
   cell_cmd_type          cmd;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [STATUS_WIDTH-1:0] status;

   logic                  takes_new [DEPTH];
   logic [TS_WIDTH-1:0]   slot_ts_ff [DEPTH];
   logic [HOST_WIDTH-1:0] slot_host_ff [DEPTH];
   logic [TAG_WIDTH-1:0]  slot_tag_ff [DEPTH];
   logic [TS_WIDTH-1:0]   slot_ts_in [DEPTH];
   logic [HOST_WIDTH-1:0] slot_host_in [DEPTH];
   logic [TAG_WIDTH-1:0]  slot_tag_in [DEPTH];

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_in;
   logic [RSP_USER_WIDTH-1:0] rsp_user_ff;
   logic [RSP_USER_WIDTH-1:0] rsp_user_in;
   logic [ENTRY_WIDTH-1:0]    head;

   assign new_ts = req_tdata[TS_WIDTH-1:0];
   assign new_host = req_tdata[TS_WIDTH+HOST_WIDTH-1:TS_WIDTH];
   assign new_tag = req_tdata[ENTRY_WIDTH-1:TS_WIDTH+HOST_WIDTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.ins = accept && (req_tuser == MODE_INSERT) && !full;
      cmd.pop = accept && (req_tuser == MODE_POP) && !empty;
      status = STATUS_OK;
      if (req_tuser == MODE_INSERT && full) begin
         status = STATUS_FULL;
      end else if (req_tuser == MODE_POP && empty) begin
         status = STATUS_EMPTY;
      end
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  occupied;
      logic                  left_takes;
      logic [TS_WIDTH-1:0]   left_ts;
      logic [HOST_WIDTH-1:0] left_host;
      logic [TAG_WIDTH-1:0]  left_tag;
      logic [TS_WIDTH-1:0]   right_ts;
      logic [HOST_WIDTH-1:0] right_host;
      logic [TAG_WIDTH-1:0]  right_tag;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_takes = 1'b0;
         assign left_ts = new_ts;
         assign left_host = new_host;
         assign left_tag = new_tag;
      end else begin : g_inner
         assign left_takes = takes_new[i-1];
         assign left_ts = slot_ts_ff[i-1];
         assign left_host = slot_host_ff[i-1];
         assign left_tag = slot_tag_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_ts = slot_ts_ff[i];
         assign right_host = slot_host_ff[i];
         assign right_tag = slot_tag_ff[i];
      end else begin : g_body
         assign right_ts = slot_ts_ff[i+1];
         assign right_host = slot_host_ff[i+1];
         assign right_tag = slot_tag_ff[i+1];
      end

      tomq_cell #(
         .TS_WIDTH(TS_WIDTH),
         .HOST_WIDTH(HOST_WIDTH),
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock(clock),
         .cmd(cmd),
         .occupied(occupied),
         .new_ts(new_ts),
         .new_host(new_host),
         .new_tag(new_tag),
         .left_takes(left_takes),
         .left_ts(left_ts),
         .left_host(left_host),
         .left_tag(left_tag),
         .right_ts(right_ts),
         .right_host(right_host),
         .right_tag(right_tag),
         .takes_new(takes_new[i]),
         .slot_ts_ff(slot_ts_ff[i]),
         .slot_host_ff(slot_host_ff[i]),
         .slot_tag_ff(slot_tag_ff[i]),
         .slot_ts_in(slot_ts_in[i]),
         .slot_host_in(slot_host_in[i]),
         .slot_tag_in(slot_tag_in[i])
      );
   end

   always_comb begin
      head = '0;
      if (count_in != '0) begin
         head = {slot_tag_in[0], slot_host_in[0], slot_ts_in[0]};
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = RSP_DATA_WIDTH'({RSP_COUNT_WIDTH'(count_in), head});
         rsp_user_in = {status, (count_in != '0)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire

FILE: design/tomq_checker.sv
// Port-level checks for the timestamp ordered message queue, bound to the top level.
`default_nettype none

module tomq_checker #(
   parameter int TS_WIDTH = 32,
   parameter int HOST_WIDTH = 8,
   parameter int TAG_WIDTH = 16,
   parameter int RSP_DATA_WIDTH = 64,
   parameter int RSP_USER_WIDTH = 3
) (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_tvalid,
   input wire                      req_tready,
   input wire                      rsp_tvalid,
   input wire                      rsp_tready,
   input wire [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire [RSP_USER_WIDTH-1:0] rsp_tuser
);
   import tomq_pkg::*;

   localparam int CNT_LSB = TS_WIDTH + HOST_WIDTH + TAG_WIDTH;

   logic [RSP_COUNT_WIDTH-1:0] rsp_count;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic                       rsp_head_valid;

   assign rsp_count = rsp_tdata[CNT_LSB+RSP_COUNT_WIDTH-1:CNT_LSB];
   assign rsp_status = rsp_tuser[STATUS_WIDTH:1];
   assign rsp_head_valid = rsp_tuser[0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STATUS_EMPTY |-> !rsp_head_valid && rsp_count == '0)
      else $error("pop on empty queue reported a head entry");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_EMPTY)
      else $error("undefined status code");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
      else $error("request side accepted while response stalled");

endmodule

bind timestamp_ordered_message_queue tomq_checker #(
   .TS_WIDTH(TS_WIDTH),
   .HOST_WIDTH(HOST_WIDTH),
   .TAG_WIDTH(TAG_WIDTH),
   .RSP_DATA_WIDTH(RSP_DATA_WIDTH),
   .RSP_USER_WIDTH(RSP_USER_WIDTH)
) u_tomq_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the timestamp ordered message queue.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tomq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int TS_W = 32;
   localparam int HOST_W = 8;
   localparam int TAG_W = 16;
   localparam int REQ_W = ((TS_W + HOST_W + TAG_W + 7) / 8) * 8;
   localparam int RSP_W = ((TS_W + HOST_W + TAG_W + RSP_COUNT_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_W = 1 + STATUS_WIDTH;
   localparam int LONG_HOLD = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_style_type;

   typedef struct packed {
      logic                       head_valid;
      logic [TS_W-1:0]            head_ts;
      logic [HOST_W-1:0]          head_host;
      logic [TAG_W-1:0]           head_tag;
      logic [RSP_COUNT_WIDTH-1:0] entry_count;
      logic [STATUS_WIDTH-1:0]    status;
   } head_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = MODE_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic [TS_W-1:0]       held_ts [QUEUE_DEPTH];
   logic [HOST_W-1:0]     held_host [QUEUE_DEPTH];
   logic [TAG_W-1:0]      held_tag [QUEUE_DEPTH];
   int                    held = 0;

   head_report_type       expected_heads[$];
   int                    error_count = 0;
   int                    burst_left = 0;
   int                    gap_max = 0;
   ready_style_type       ready_style = READY_ALWAYS;
   int                    holds_asked = 0;
   int                    holds_served = 0;
   int                    hold_left = 0;
   int                    ready_cycle = 0;
   int                    stall_cycles = 0;

   timestamp_ordered_message_queue #(
      .DEPTH(QUEUE_DEPTH),
      .TS_WIDTH(TS_W),
      .HOST_WIDTH(HOST_W),
      .TAG_WIDTH(TAG_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic head_report_type predict_head(logic mode, logic [TS_W-1:0] ts,
                                                    logic [HOST_W-1:0] host,
                                                    logic [TAG_W-1:0] tag);
      head_report_type r;
      int pos;
      r = '0;
      r.status = STATUS_OK;
      if (mode == MODE_INSERT) begin
         if (held >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < held && (ts > held_ts[pos] ||
                                  (ts == held_ts[pos] && host > held_host[pos])))
               pos++;
            for (int i = held; i > pos; i--) begin
               held_ts[i] = held_ts[i-1];
               held_host[i] = held_host[i-1];
               held_tag[i] = held_tag[i-1];
            end
            held_ts[pos] = ts;
            held_host[pos] = host;
            held_tag[pos] = tag;
            held++;
         end
      end else if (held == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         for (int i = 1; i < held; i++) begin
            held_ts[i-1] = held_ts[i];
            held_host[i-1] = held_host[i];
            held_tag[i-1] = held_tag[i];
         end
         held--;
      end
      if (held > 0) begin
         r.head_valid = 1'b1;
         r.head_ts = held_ts[0];
         r.head_host = held_host[0];
         r.head_tag = held_tag[0];
      end
      r.entry_count = RSP_COUNT_WIDTH'(held);
      return r;
   endfunction

   task automatic send_request(input logic mode, input logic [TS_W-1:0] ts,
                               input logic [HOST_W-1:0] host, input logic [TAG_W-1:0] tag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= REQ_W'({tag, host, ts});
      do @(posedge clock); while (!req_tready);
      expected_heads.push_back(predict_head(mode, ts, host, tag));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_heads.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic check_response();
      head_report_type want;
      if (expected_heads.size() == 0) begin
         report_mismatch("unexpected response", rsp_tdata, '0);
      end else begin
         want = expected_heads.pop_front();
         if (rsp_tuser[0] !== want.head_valid)
            report_mismatch("head_valid", rsp_tuser[0], want.head_valid);
         if (rsp_tuser[2:1] !== want.status)
            report_mismatch("status", rsp_tuser[2:1], want.status);
         if (rsp_tdata[TS_W-1:0] !== want.head_ts)
            report_mismatch("head_timestamp", rsp_tdata[TS_W-1:0], want.head_ts);
         if (rsp_tdata[TS_W+HOST_W-1:TS_W] !== want.head_host)
            report_mismatch("head_host", rsp_tdata[TS_W+HOST_W-1:TS_W], want.head_host);
         if (rsp_tdata[TS_W+HOST_W+TAG_W-1:TS_W+HOST_W] !== want.head_tag)
            report_mismatch("head_tag", rsp_tdata[TS_W+HOST_W+TAG_W-1:TS_W+HOST_W],
                            want.head_tag);
         if (rsp_tdata[TS_W+HOST_W+TAG_W+RSP_COUNT_WIDTH-1:TS_W+HOST_W+TAG_W]
             !== want.entry_count)
            report_mismatch("entry_count",
                            rsp_tdata[TS_W+HOST_W+TAG_W+RSP_COUNT_WIDTH-1:TS_W+HOST_W+TAG_W],
                            want.entry_count);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         check_response();
   end

   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_style)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 99) < 65);
            end
            default: begin
               rsp_tready <= ((ready_cycle % 9) < 5);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [TS_W-1:0] pick_ts(bit narrow);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return narrow ? TS_W'($urandom_range(0, 7)) : TS_W'($urandom);
      endcase
   endfunction

   function automatic logic [HOST_W-1:0] pick_host(bit narrow);
      return narrow ? HOST_W'($urandom_range(0, 3)) : HOST_W'($urandom_range(0, 255));
   endfunction

   task automatic pick_idling();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      case ($urandom_range(0, 2))
         0: ready_style <= READY_ALWAYS;
         1: ready_style <= READY_RANDOM;
         default: ready_style <= READY_PERIODIC;
      endcase
   endtask

   task automatic run_mix(input int count, input int insert_pct, input bit narrow,
                          input bit vary_idling);
      for (int n = 0; n < count; n++) begin
         if (vary_idling && n % 60 == 0)
            pick_idling();
         send_request(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP,
                      pick_ts(narrow), pick_host(narrow), TAG_W'($urandom));
      end
   endtask

   task automatic test_pop_on_empty();
      send_request(MODE_POP, TS_W'($urandom), HOST_W'($urandom), TAG_W'($urandom));
   endtask

   task automatic test_key_order();
      send_request(MODE_INSERT, '1, '1, '1);
      send_request(MODE_INSERT, '0, '0, '0);
      send_request(MODE_INSERT, '0, '0, TAG_W'(16'h1234));
      send_request(MODE_INSERT, '0, HOST_W'(1), TAG_W'(16'h00ff));
      send_request(MODE_INSERT, '0, '1, TAG_W'(16'hff00));
      send_request(MODE_POP, '1, '1, '1);
   endtask

   task automatic test_full_queue();
      while (held < QUEUE_DEPTH)
         send_request(MODE_INSERT, TS_W'($urandom), pick_host(0), TAG_W'($urandom));
      send_request(MODE_INSERT, '0, '0, TAG_W'(16'hbeef));
      send_request(MODE_POP, '0, '0, '0);
      send_request(MODE_INSERT, '1, '1, TAG_W'(16'h5a5a));
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++)
         run_mix(100, (phase % 2 == 0) ? $urandom_range(60, 90) : $urandom_range(10, 40),
                 1'b0, 1'b1);
   endtask

   task automatic test_tied_keys();
      run_mix(125, 75, 1'b1, 1'b1);
      run_mix(125, 30, 1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      gap_max = 0;
      ready_style <= READY_ALWAYS;
      holds_asked <= holds_asked + 1;
      run_mix(75, 70, 1'b0, 1'b0);
      wait_for_drain();
      ready_style <= READY_RANDOM;
      holds_asked <= holds_asked + 1;
      run_mix(75, 40, 1'b1, 1'b0);
      wait_for_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      ready_style <= READY_RANDOM;
      gap_max = 4;
      test_pop_on_empty();
      test_key_order();
      test_full_queue();
      test_random_traffic();
      test_tied_keys();
      test_backpressure();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_heads.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
